FILE: rtl/embedding_mlp_hidden_layer_core_defines.svh
// Assertion macros for the RTL file that checks its own logic (emlp_back).
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef EMBEDDING_MLP_HIDDEN_LAYER_CORE_DEFINES_SVH
`define EMBEDDING_MLP_HIDDEN_LAYER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EMLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/emlp_pkg.sv
`default_nettype none

package emlp_pkg;

  localparam int EMBED_DIM    = 8;
  localparam int CONTEXT_LEN  = 4;
  localparam int HIDDEN_UNITS = 32;
  localparam int NUM_TOKENS   = 27;
  localparam int FRAC_BITS    = 12;

  localparam int EMB_WORDS = NUM_TOKENS * EMBED_DIM;
  localparam int VEC_LEN   = CONTEXT_LEN * EMBED_DIM;
  localparam int W_WORDS   = VEC_LEN * HIDDEN_UNITS;

  localparam int WORD_W = 16;
  localparam int ADDR_W = 10;
  localparam int CHAR_W = 8;
  localparam int TOK_W  = 5;
  localparam int OUT_UNIT_W = 5;
  localparam int ACT_W  = 15;
  localparam int ACT_MAX = 32767;

  localparam int EMB_AW  = (EMB_WORDS > 1) ? $clog2(EMB_WORDS) : 1;
  localparam int WGT_AW  = (W_WORDS > 1) ? $clog2(W_WORDS) : 1;
  localparam int UNIT_W  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int CTX_W   = (CONTEXT_LEN > 1) ? $clog2(CONTEXT_LEN) : 1;
  localparam int DIM_W   = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int ACC_W   = PROD_W + $clog2(VEC_LEN + 1) + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    REQ_EMB  = 2'd0,
    REQ_WGT  = 2'd1,
    REQ_BIAS = 2'd2,
    REQ_CHAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_RUN,
    BACK_DRAIN
  } back_state_t;

  typedef struct packed {
    req_t                     kind;
    logic [ADDR_W-1:0]        addr;
    logic signed [WORD_W-1:0] value;
    logic [TOK_W-1:0]         token;
  } qentry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  // Period maps to token 0, lower-case letters to 1..26, anything else to 0.
  function automatic logic [TOK_W-1:0] char_token(input logic [CHAR_W-1:0] c);
    logic [TOK_W-1:0] tok;
    tok = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      tok = TOK_W'(c - 8'h60);
    end
    return tok;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/emlp_front.sv
`default_nettype none

module emlp_front
  import emlp_pkg::*;
(
  input  wire logic                     start,
  input  wire logic [1:0]               in_req_type,
  input  wire logic [ADDR_W-1:0]        in_table_addr,
  input  wire logic signed [WORD_W-1:0] in_load_value,
  input  wire logic [CHAR_W-1:0]        in_char_code,
  input  wire qstat_t                   qstat,
  output logic                          busy,
  output logic                          push,
  output qentry_t                       entry
);

  logic [31:0] addr_ext;
  logic        keep;
  req_t        kind;

  assign addr_ext = 32'(in_table_addr);
  assign kind     = req_t'(in_req_type);
  assign busy     = qstat.full;

  // Loads that fall outside their table are accepted and dropped here.
  always_comb begin
    keep = 1'b0;
    case (kind)
      REQ_EMB:  keep = addr_ext < 32'(EMB_WORDS);
      REQ_WGT:  keep = addr_ext < 32'(W_WORDS);
      REQ_BIAS: keep = addr_ext < 32'(HIDDEN_UNITS);
      REQ_CHAR: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign push        = start && !qstat.full && keep;
  assign entry.kind  = kind;
  assign entry.addr  = in_table_addr;
  assign entry.value = in_load_value;
  assign entry.token = char_token(in_char_code);

endmodule

`default_nettype wire

FILE: rtl/emlp_queue.sv
`default_nettype none

module emlp_queue
  import emlp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire qentry_t push_entry,
  input  wire logic    pop,
  output qentry_t      head,
  output qstat_t       qstat
);

  qentry_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign qstat.full      = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign qstat.not_empty = cnt_r != '0;
  assign head            = mem_r[rd_ptr_r];

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && qstat.not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/emlp_back.sv
`default_nettype none
`include "embedding_mlp_hidden_layer_core_defines.svh"

module emlp_back
  import emlp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qstat_t          qstat,
  input  wire qentry_t         q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [OUT_UNIT_W-1:0] out_unit_index,
  output logic [ACT_W-1:0]     out_activation,
  output logic                 out_last_unit
);

  back_state_t state_r, state_nxt;
  logic [CTX_W-1:0]  tok_cnt_r, tok_cnt_nxt;
  logic [UNIT_W-1:0] u_r, u_nxt;
  logic [CTX_W-1:0]  c_r, c_nxt;
  logic [DIM_W-1:0]  d_r, d_nxt;
  logic [WGT_AW-1:0] w_addr_r, w_addr_nxt;
  logic [TOK_W-1:0]  tok_r [CONTEXT_LEN];

  logic issue, k_first, k_last;
  logic tok_we, emb_we, wgt_we, bias_we;
  logic [EMB_AW-1:0] emb_raddr;

  logic signed [WORD_W-1:0] emb_mem  [EMB_WORDS];
  logic signed [WORD_W-1:0] wgt_mem  [W_WORDS];
  logic signed [WORD_W-1:0] bias_mem [HIDDEN_UNITS];
  logic signed [WORD_W-1:0] emb_rdata_r, wgt_rdata_r, bias_rdata_r;

  logic              s1_v_r, s1_first_r, s1_last_r;
  logic [UNIT_W-1:0] s1_unit_r;
  logic              s2_v_r, s2_first_r, s2_last_r;
  logic [UNIT_W-1:0] s2_unit_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [WORD_W-1:0] s2_bias_r;

  logic signed [ACC_W-1:0] acc_r, acc_sum, bias_term, prod_ext;
  logic                    fin_v_r;
  logic [UNIT_W-1:0]       fin_unit_r;
  logic signed [ACC_W-1:0] fin_acc_r, rnd, scaled;
  logic [ACT_W-1:0]        act;

  logic                  out_v_r, out_last_r;
  logic [OUT_UNIT_W-1:0] out_unit_r;
  logic [ACT_W-1:0]      out_act_r;

  assign k_first = (c_r == '0) && (d_r == '0);
  assign k_last  = (c_r == CTX_W'(CONTEXT_LEN - 1)) && (d_r == DIM_W'(EMBED_DIM - 1));

  always_comb begin
    state_nxt   = state_r;
    tok_cnt_nxt = tok_cnt_r;
    u_nxt       = u_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    w_addr_nxt  = w_addr_r;
    q_pop       = 1'b0;
    issue       = 1'b0;
    tok_we      = 1'b0;
    emb_we      = 1'b0;
    wgt_we      = 1'b0;
    bias_we     = 1'b0;
    case (state_r)
      BACK_IDLE: begin
        if (qstat.not_empty) begin
          q_pop = 1'b1;
          case (q_entry.kind)
            REQ_EMB:  emb_we  = 1'b1;
            REQ_WGT:  wgt_we  = 1'b1;
            REQ_BIAS: bias_we = 1'b1;
            REQ_CHAR: begin
              tok_we = 1'b1;
              if (tok_cnt_r == CTX_W'(CONTEXT_LEN - 1)) begin
                tok_cnt_nxt = '0;
                state_nxt   = BACK_RUN;
                u_nxt       = '0;
                c_nxt       = '0;
                d_nxt       = '0;
                w_addr_nxt  = '0;
              end else begin
                tok_cnt_nxt = tok_cnt_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BACK_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          c_nxt = '0;
          d_nxt = '0;
          if (u_r == UNIT_W'(HIDDEN_UNITS - 1)) begin
            state_nxt = BACK_DRAIN;
          end else begin
            u_nxt      = u_r + 1'b1;
            w_addr_nxt = WGT_AW'(u_r) + WGT_AW'(1);
          end
        end else begin
          // Weights of one unit sit HIDDEN_UNITS words apart.
          w_addr_nxt = w_addr_r + WGT_AW'(HIDDEN_UNITS);
          if (d_r == DIM_W'(EMBED_DIM - 1)) begin
            d_nxt = '0;
            c_nxt = c_r + 1'b1;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      BACK_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !fin_v_r) begin
          state_nxt = BACK_IDLE;
        end
      end
      default: state_nxt = BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BACK_IDLE;
      tok_cnt_r <= '0;
      u_r       <= '0;
      c_r       <= '0;
      d_r       <= '0;
      w_addr_r  <= '0;
      for (int i = 0; i < CONTEXT_LEN; i++) begin
        tok_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      tok_cnt_r <= tok_cnt_nxt;
      u_r       <= u_nxt;
      c_r       <= c_nxt;
      d_r       <= d_nxt;
      w_addr_r  <= w_addr_nxt;
      if (tok_we) begin
        tok_r[tok_cnt_r] <= q_entry.token;
      end
    end
  end

  assign emb_raddr = EMB_AW'(32'(tok_r[c_r]) * EMBED_DIM + 32'(d_r));

  always_ff @(posedge clk) begin
    if (emb_we) begin
      emb_mem[EMB_AW'(q_entry.addr)] <= q_entry.value;
    end
    emb_rdata_r <= emb_mem[emb_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[WGT_AW'(q_entry.addr)] <= q_entry.value;
    end
    wgt_rdata_r <= wgt_mem[w_addr_r];
  end

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[UNIT_W'(q_entry.addr)] <= q_entry.value;
    end
    bias_rdata_r <= bias_mem[u_r];
  end

  assign bias_term = ACC_W'(s2_bias_r) <<< FRAC_BITS;
  assign prod_ext  = ACC_W'(s2_prod_r);
  assign acc_sum   = (s2_first_r ? bias_term : acc_r) + prod_ext;

  // A negative or zero sum gives 0; round half up on the positive sum, then clamp to the largest code.
  assign rnd    = fin_acc_r + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign scaled = rnd >>> FRAC_BITS;
  always_comb begin
    if (fin_acc_r[ACC_W-1] || fin_acc_r == '0) begin
      act = '0;
    end else if (scaled > ACC_W'(ACT_MAX)) begin
      act = ACT_W'(ACT_MAX);
    end else begin
      act = ACT_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      fin_v_r <= s2_v_r && s2_last_r;
      out_v_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= k_first;
    s1_last_r  <= k_last;
    s1_unit_r  <= u_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_unit_r  <= s1_unit_r;
    s2_prod_r  <= wgt_rdata_r * emb_rdata_r;
    s2_bias_r  <= bias_rdata_r;
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
    if (s2_v_r && s2_last_r) begin
      fin_acc_r  <= acc_sum;
      fin_unit_r <= s2_unit_r;
    end
    out_act_r  <= act;
    out_unit_r <= OUT_UNIT_W'(fin_unit_r);
    out_last_r <= fin_unit_r == UNIT_W'(HIDDEN_UNITS - 1);
  end

  assign out_valid      = out_v_r;
  assign out_unit_index = out_unit_r;
  assign out_activation = out_act_r;
  assign out_last_unit  = out_last_r;

  `EMLP_ASSERT_NEXT(a_last_term_finishes, s2_v_r && s2_last_r, fin_v_r, "last term did not finish a unit")
  `EMLP_ASSERT_NEXT(a_finish_reaches_out, fin_v_r, out_valid, "finished unit was not reported")
  `EMLP_ASSERT_SAME(a_issue_not_idle, s1_v_r, state_r != BACK_IDLE, "read data arrived while idle")
  `EMLP_ASSERT_NEXT(a_gap_after_last, out_valid && out_last_unit, !out_valid, "result right after last unit")

endmodule

`default_nettype wire

FILE: rtl/embedding_mlp_hidden_layer_core.sv
// The back end writes load items into their tables while idle; a character that completes
// a context starts the work of all HIDDEN_UNITS units on one shared multiply-accumulate. The
// back end takes no new queue item until the last unit is finished; a two-item queue lets
// loads follow at once until it is full. Results come one unit at a time, in unit order, on a
// one-cycle strobe. Synchronous active-low reset clears the queue, token count, tokens and
// pipeline; the three tables are not cleared and hold nothing until loaded.
`default_nettype none

module embedding_mlp_hidden_layer_core
  import emlp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_req_type,
  input  wire logic [ADDR_W-1:0]        in_table_addr,
  input  wire logic signed [WORD_W-1:0] in_load_value,
  input  wire logic [CHAR_W-1:0]        in_char_code,
  output logic                          out_valid,
  output logic [OUT_UNIT_W-1:0]         out_unit_index,
  output logic [ACT_W-1:0]              out_activation,
  output logic                          out_last_unit
);

  qstat_t  qstat;
  qentry_t push_entry;
  qentry_t head;
  logic    push;
  logic    pop;

  emlp_front u_front (
    .start         (start),
    .in_req_type   (in_req_type),
    .in_table_addr (in_table_addr),
    .in_load_value (in_load_value),
    .in_char_code  (in_char_code),
    .qstat         (qstat),
    .busy          (busy),
    .push          (push),
    .entry         (push_entry)
  );

  emlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  emlp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qstat          (qstat),
    .q_entry        (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_unit_index (out_unit_index),
    .out_activation (out_activation),
    .out_last_unit  (out_last_unit)
  );

endmodule

`default_nettype wire
